@@ sv/bcle_pkg.sv @@
package bcle_pkg;

  // List geometry.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TOTAL_W  = 5;

  // Command codes; code seven is unused and is answered with status ok.
  typedef enum logic [2:0] {
    CMD_SHOW      = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AFTER = 3'd5,
    CMD_CLEAR     = 3'd6
  } cmd_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Operation broadcast to every cell.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_APPEND,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  // Controller state.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SHOW,
    S_SEARCH
  } state_e;

  // Command transaction.
  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } request_t;

  // Result transaction.
  typedef struct packed {
    logic signed [31:0]   value_out;
    logic [1:0]           status;
    logic [TOTAL_W-1:0]   entry_total;
    logic                 last;
  } result_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e           op;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    logic signed [31:0] data;
  } cell_ctrl_t;

endpackage

@@ sv/bounded_circular_list_engine_top.sv @@
// Channel   Handshake                 Payload    Direction
// command   start high, busy low      request    in
// result    strobe high for 1 cycle   result     out
//
// Insert, delete, clear and unused codes finish at decode; the result is registered.
// Display emits one element per result (an empty list is answered at decode); the
// chain rotates once per cycle and the head cell supplies each value. Delete-after scans
// the positions up to the tail, stopping at a hit, as it checks one match flag a cycle.
// Reset (synchronous) empties the list; cell contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bounded_circular_list_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bcle_pkg::request_t request,
  output logic               strobe,
  output bcle_pkg::result_t  result
);

  localparam int N  = bcle_pkg::CAPACITY;
  localparam int IW = bcle_pkg::IDX_W;
  localparam int CW = bcle_pkg::CNT_W;
  localparam int TW = bcle_pkg::TOTAL_W;

  bcle_pkg::state_e     state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        k, k_next;
  logic signed [31:0]   key, key_next;
  logic                 strobe_next;
  bcle_pkg::result_t    result_next;
  bcle_pkg::cell_ctrl_t ctrl;

  logic signed [31:0]   cell_value [N];
  logic [N-1:0]         match;
  logic                 at_end;

  // Row of cells; each passes its value to both neighbors.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = ctrl.data;
    end else begin : g_mid
      assign left_in = cell_value[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_in = cell_value[i];
    end else begin : g_inner
      assign right_in = cell_value[i+1];
    end

    bcle_cell u_cell (
      .clk   (clk),
      .index (IW'(i)),
      .ctrl  (ctrl),
      .left  (left_in),
      .right (right_in),
      .head  (cell_value[0]),
      .value (cell_value[i]),
      .match (match[i])
    );
  end

  assign busy   = (state != bcle_pkg::S_IDLE);
  assign at_end = (CW'(k) == count - CW'(1));

  // Command decode, display walk and search scan.
  always_comb begin
    state_next  = state;
    count_next  = count;
    k_next      = k;
    key_next    = key;
    strobe_next = 1'b0;
    result_next.value_out   = '0;
    result_next.status      = bcle_pkg::ST_OK;
    result_next.entry_total = '0;
    result_next.last        = 1'b1;
    ctrl.op    = bcle_pkg::CELL_HOLD;
    ctrl.pos   = '0;
    ctrl.count = count;
    ctrl.data  = key;

    unique case (state)
      bcle_pkg::S_IDLE: begin
        if (start) begin
          ctrl.data   = request.value;
          key_next    = request.value;
          strobe_next = 1'b1;
          unique case (request.command)
            bcle_pkg::CMD_SHOW: begin
              if (count == '0) begin
                result_next.status = bcle_pkg::ST_EMPTY;
              end else begin
                strobe_next = 1'b0;
                k_next      = '0;
                state_next  = bcle_pkg::S_SHOW;
              end
            end
            bcle_pkg::CMD_INS_FRONT: begin
              if (count == CW'(N)) begin
                result_next.status = bcle_pkg::ST_FULL;
              end else begin
                ctrl.op    = bcle_pkg::CELL_PUSH;
                count_next = count + CW'(1);
              end
            end
            bcle_pkg::CMD_INS_BACK: begin
              if (count == CW'(N)) begin
                result_next.status = bcle_pkg::ST_FULL;
              end else begin
                ctrl.op    = bcle_pkg::CELL_APPEND;
                count_next = count + CW'(1);
              end
            end
            bcle_pkg::CMD_DEL_FRONT: begin
              if (count == '0) begin
                result_next.status = bcle_pkg::ST_EMPTY;
              end else begin
                ctrl.op    = bcle_pkg::CELL_REMOVE;
                ctrl.pos   = '0;
                count_next = count - CW'(1);
              end
            end
            bcle_pkg::CMD_DEL_BACK: begin
              if (count == '0) begin
                result_next.status = bcle_pkg::ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            bcle_pkg::CMD_DEL_AFTER: begin
              if (count == '0) begin
                result_next.status = bcle_pkg::ST_EMPTY;
              end else begin
                strobe_next = 1'b0;
                k_next      = '0;
                state_next  = bcle_pkg::S_SEARCH;
              end
            end
            bcle_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Emit the head and rotate the list by one; after count steps it is restored.
      bcle_pkg::S_SHOW: begin
        ctrl.op               = bcle_pkg::CELL_ROTATE;
        strobe_next           = 1'b1;
        result_next.value_out = cell_value[0];
        result_next.last      = at_end;
        if (at_end) begin
          state_next = bcle_pkg::S_IDLE;
        end else begin
          k_next = k + IW'(1);
        end
      end

      // Check one position per cycle; on a hit remove its circular successor.
      bcle_pkg::S_SEARCH: begin
        if (match[k]) begin
          strobe_next = 1'b1;
          state_next  = bcle_pkg::S_IDLE;
          count_next  = count - CW'(1);
          if (count != CW'(1)) begin
            ctrl.op  = bcle_pkg::CELL_REMOVE;
            ctrl.pos = at_end ? '0 : CW'(k) + CW'(1);
          end
        end else if (at_end) begin
          strobe_next        = 1'b1;
          result_next.status = bcle_pkg::ST_NOT_FOUND;
          state_next         = bcle_pkg::S_IDLE;
        end else begin
          k_next = k + IW'(1);
        end
      end

      default: begin
        state_next = bcle_pkg::S_IDLE;
      end
    endcase

    result_next.entry_total = TW'(count_next);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bcle_pkg::S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    k      <= k_next;
    key    <= key_next;
    result <= result_next;
  end

endmodule

@@ sv/bcle_cell.sv @@
module bcle_cell (
  input  logic                         clk,
  input  logic [bcle_pkg::IDX_W-1:0]   index,
  input  bcle_pkg::cell_ctrl_t         ctrl,
  input  logic signed [31:0]           left,
  input  logic signed [31:0]           right,
  input  logic signed [31:0]           head,
  output logic signed [31:0]           value,
  output logic                         match
);

  localparam int CW = bcle_pkg::CNT_W;

  logic [CW-1:0]      slot;
  logic signed [31:0] value_next;

  assign slot  = CW'(index);
  assign match = (value == ctrl.data);

  // Pick the new content from this cell, a neighbor, the head or the new value.
  always_comb begin
    value_next = value;
    unique case (ctrl.op)
      bcle_pkg::CELL_HOLD: begin
        value_next = value;
      end
      bcle_pkg::CELL_PUSH: begin
        value_next = (slot == '0) ? ctrl.data : left;
      end
      bcle_pkg::CELL_APPEND: begin
        value_next = (slot == ctrl.count) ? ctrl.data : value;
      end
      bcle_pkg::CELL_REMOVE: begin
        value_next = (slot >= ctrl.pos) ? right : value;
      end
      bcle_pkg::CELL_ROTATE: begin
        if (slot == ctrl.count - CW'(1)) begin
          value_next = head;
        end else if (slot < ctrl.count - CW'(1)) begin
          value_next = right;
        end else begin
          value_next = value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ test/tb_bounded_circular_list_engine_top.sv @@
`timescale 1ns / 100ps

module tb_bounded_circular_list_engine_top;
  import bcle_pkg::*;

  // Code seven has no meaning; the block answers it with status ok.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int ITEM_TARGET = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  // Shadow of the list, the queue of predicted results and the comparison.
  class list_scoreboard;
    logic signed [31:0] entries[$];
    result_t pending_results[$];
    int errors;
    int checked;
    int status_seen[4];

    function new();
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR: %s", msg);
      errors++;
    endtask

    function int pending();
      return pending_results.size();
    endfunction

    function int held();
      return entries.size();
    endfunction

    // Returns a value present in the list, for searches that should hit.
    function logic signed [31:0] pick_member();
      return entries[$urandom_range(0, entries.size() - 1)];
    endfunction

    function void push_result(logic signed [31:0] data, status_e st, logic fin);
      result_t r;
      r.value_out = data;
      r.status = st;
      r.entry_total = TOTAL_W'(entries.size());
      r.last = fin;
      pending_results.push_back(r);
    endfunction

    // Updates the shadow list for one accepted command and queues its results.
    function void apply_command(logic [2:0] code, logic signed [31:0] operand);
      status_e st;
      int hit;
      st = ST_OK;
      hit = -1;
      case (code)
        CMD_SHOW: begin
          if (entries.size() == 0) begin
            push_result('0, ST_EMPTY, 1'b1);
          end else begin
            foreach (entries[i]) push_result(entries[i], ST_OK, i == entries.size() - 1);
          end
          return;
        end
        CMD_INS_FRONT: begin
          if (entries.size() >= CAPACITY) st = ST_FULL;
          else entries.push_front(operand);
        end
        CMD_INS_BACK: begin
          if (entries.size() >= CAPACITY) st = ST_FULL;
          else entries.push_back(operand);
        end
        CMD_DEL_FRONT: begin
          if (entries.size() == 0) st = ST_EMPTY;
          else void'(entries.pop_front());
        end
        CMD_DEL_BACK: begin
          if (entries.size() == 0) st = ST_EMPTY;
          else void'(entries.pop_back());
        end
        CMD_DEL_AFTER: begin
          if (entries.size() == 0) begin
            st = ST_EMPTY;
          end else begin
            foreach (entries[i]) if (hit < 0 && entries[i] == operand) hit = i;
            // The successor of the tail is the head.
            if (hit < 0) st = ST_NOT_FOUND;
            else if (hit == entries.size() - 1) entries.delete(0);
            else entries.delete(hit + 1);
          end
        end
        CMD_CLEAR: entries.delete();
        default: ;
      endcase
      push_result('0, st, 1'b1);
    endfunction

    // Compares one result transaction with the oldest prediction.
    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing predicted: %h", got));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      status_seen[got.status]++;
      if (got.value_out !== want.value_out)
        report($sformatf("value_out %0d, predicted %0d", got.value_out, want.value_out));
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.entry_total !== want.entry_total)
        report($sformatf("entry_total %0d, predicted %0d", got.entry_total, want.entry_total));
      if (got.last !== want.last)
        report($sformatf("last %0b, predicted %0b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t request = '0;
  logic strobe;
  result_t result;

  list_scoreboard sb = new();
  int sent = 0;
  int cycle_count = 0;
  bit burst_mode = 1'b0;

  bounded_circular_list_engine_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Each strobed result is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(strobe)) sb.report("strobe is unknown");
      else if (strobe) sb.check_result(result);
    end
  end

  // Presents one command and holds it until the block takes it.
  task automatic send_command(input logic [2:0] code, input logic signed [31:0] operand);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= '{command: code, value: operand};
    do @(posedge clk); while (busy !== 1'b0);
    sb.apply_command(code, operand);
    sent++;
  endtask

  // Draws a command code with weights that depend on the current mix.
  function automatic logic [2:0] pick_code(mix_e mix);
    int weight[8];
    int roll;
    int total;
    case (mix)
      MIX_FILL:  weight = '{10, 35, 35, 4, 4, 10, 1, 1};
      MIX_DRAIN: weight = '{10, 10, 10, 22, 22, 24, 0, 2};
      default:   weight = '{12, 18, 18, 14, 14, 18, 3, 3};
    endcase
    total = 0;
    foreach (weight[i]) total += weight[i];
    roll = $urandom_range(0, total - 1);
    foreach (weight[i]) begin
      if (roll < weight[i]) return 3'(i);
      roll -= weight[i];
    end
    return CMD_SHOW;
  endfunction

  // Small values repeat often, so searches see duplicates; the rest span all bits.
  function automatic logic signed [31:0] pick_operand(logic [2:0] code);
    if (code == CMD_DEL_AFTER && sb.held() > 0 && $urandom_range(0, 3) != 0)
      return sb.pick_member();
    if ($urandom_range(0, 1) == 0)
      return $signed(32'($urandom_range(0, 7))) - 32'sd4;
    return $signed($urandom());
  endfunction

  initial begin
    mix_e mix;
    int span;
    logic [2:0] code;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: empty list, unused code, one-element list, wrapped successor.
    send_command(CMD_SHOW, 32'sd0);
    send_command(CMD_DEL_FRONT, 32'sd0);
    send_command(CMD_DEL_BACK, 32'sd0);
    send_command(CMD_DEL_AFTER, 32'sd5);
    send_command(CMD_CLEAR, 32'sd0);
    send_command(CMD_UNUSED, -32'sd1);
    send_command(CMD_INS_FRONT, 32'sh8000_0000);
    send_command(CMD_DEL_AFTER, 32'sh8000_0000);
    send_command(CMD_INS_BACK, 32'sh7fff_ffff);
    send_command(CMD_INS_FRONT, 32'sd0);
    send_command(CMD_INS_BACK, -32'sd1);
    send_command(CMD_SHOW, 32'sd0);
    send_command(CMD_DEL_AFTER, 32'sd12345);
    send_command(CMD_DEL_AFTER, -32'sd1);
    send_command(CMD_SHOW, 32'sd0);
    send_command(CMD_DEL_BACK, 32'sd0);
    send_command(CMD_DEL_FRONT, 32'sd0);
    send_command(CMD_INS_BACK, 32'sd7);
    send_command(CMD_DEL_BACK, 32'sd0);
    send_command(CMD_INS_BACK, 32'sd3);
    send_command(CMD_INS_FRONT, 32'sd3);
    send_command(CMD_CLEAR, 32'sd0);

    // Fill past capacity, show the full list, then empty it by searches.
    repeat (CAPACITY + 2) begin
      code = ($urandom_range(0, 1) == 0) ? CMD_INS_FRONT : CMD_INS_BACK;
      send_command(code, pick_operand(code));
    end
    send_command(CMD_SHOW, 32'sd0);
    while (sb.held() > 0) send_command(CMD_DEL_AFTER, sb.pick_member());
    send_command(CMD_DEL_AFTER, 32'sd0);

    // Random phases that lean toward growing, shrinking or neither.
    while (sent < ITEM_TARGET) begin
      mix = mix_e'($urandom_range(0, 2));
      burst_mode = ($urandom_range(0, 2) == 0);
      span = $urandom_range(15, 40);
      repeat (span) begin
        code = pick_code(mix);
        send_command(code, pick_operand(code));
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d results in %0d cycles.", sent, sb.checked,
             cycle_count);
    $display("Status counts: ok %0d, empty %0d, full %0d, no match %0d.", sb.status_seen[0],
             sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ bounded_circular_list_engine_top.f @@
sv/bcle_pkg.sv
sv/bcle_cell.sv
sv/bounded_circular_list_engine_top.sv
test/tb_bounded_circular_list_engine_top.sv
